// ===== rtl/rbd_pkg.sv =====
// Shared constants and types of the RGBA 2x2 box downsampler.
`default_nettype none
package rbd_pkg;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int ADDR_W        = $clog2(MAX_OUT_WIDTH);
    localparam int CNT_W         = $clog2(MAX_OUT_WIDTH + 1);

    localparam int NUM_CH  = 4;
    localparam int CODE_W  = 8;
    localparam int PAIR_W  = CODE_W + 1;
    localparam int AVG_W   = CODE_W + 2;
    localparam int LINE_W  = NUM_CH * PAIR_W;

    localparam int WIDTH_CFG_W = 11;
    localparam int CFG_W       = WIDTH_CFG_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WIDTH_CFG_W-1:0] OUT_WIDTH_RESET = WIDTH_CFG_W'(400);
    localparam logic                   HALVE_RESET     = 1'b1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_OUT_WIDTH    = 1'b0;
    localparam cfg_idx_t REG_HALVE_ENABLE = 1'b1;

    typedef struct packed {
        logic              hold_en;
        logic              pass;
        logic              emit;
        logic              mem_wr;
        logic              mem_rd;
        logic [ADDR_W-1:0] addr;
    } rbd_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rbd_if.sv =====
// Pixel stream interfaces: full-resolution input words and averaged output words.
`default_nettype none
interface rbd_in_if;
    import rbd_pkg::*;
    logic              valid;
    logic              ready;
    logic              start_of_image;
    logic [CODE_W-1:0] red_in;
    logic [CODE_W-1:0] green_in;
    logic [CODE_W-1:0] blue_in;
    logic [CODE_W-1:0] alpha_in;

    modport source (output valid, start_of_image, red_in, green_in, blue_in, alpha_in,
                    input ready);
    modport sink   (input valid, start_of_image, red_in, green_in, blue_in, alpha_in,
                    output ready);
endinterface

interface rbd_out_if;
    import rbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] red_avg;
    logic [AVG_W-1:0] green_avg;
    logic [AVG_W-1:0] blue_avg;
    logic [AVG_W-1:0] alpha_avg;

    modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, input ready);
    modport sink   (input valid, red_avg, green_avg, blue_avg, alpha_avg, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgba_box_downsample_2x2_unit.sv =====
// Top level of the RGBA 2x2 box downsampler: control, four channel lanes, line store.
// Usage:
//   pix_in carries one full-resolution RGBA pixel per word in raster order;
//   start_of_image marks the first pixel of a frame. pix_out carries one word
//   per 2x2 block (halve_enable=1, on the block's bottom-right pixel, the sum of
//   its four codes) or one per pixel (halve_enable=0, the code), in 8.2 fixed point.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 out_width, 1 halve_enable); write only while the block is idle.
// Timing:
//   One pixel per clock sustained while pix_out.ready is high. The accepting
//   edge of a result word's last pixel loads the middle stage (registered line
//   store read, pair sums); the output register, which adds the row above,
//   loads from the middle stage when the output is empty or pix_out.ready is high.
// Reset:
//   Counters and pipeline valids clear; out_width=400, halve_enable=1. The line
//   store is not cleared; odd rows only read entries the even row above wrote.
// Stall:
//   When pix_out.ready is low, a word in the output register holds, and a word in
//   the middle stage waits behind it; pix_in.ready drops only when both hold words.
`default_nettype none
module rgba_box_downsample_2x2_unit
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rbd_in_if.sink                         pix_in,
    rbd_out_if.source                      pix_out,
    input  wire logic                      cfg_we,
    input  wire rbd_pkg::cfg_idx_t         cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0] cfg_wdata
);
    import rbd_pkg::*;

    rbd_ctl_t ctl;

    logic s1_valid_reg, s1_valid_next;
    logic s1_pass_reg;
    logic out_valid_reg, out_valid_next;
    logic s1_en, s2_en, fire;

    logic [LINE_W-1:0] line_mem [MAX_OUT_WIDTH];
    logic [LINE_W-1:0] above_reg;
    logic [LINE_W-1:0] wr_data;

    logic [CODE_W-1:0] codes [NUM_CH];
    logic [AVG_W-1:0]  avgs  [NUM_CH];

    assign s2_en        = !out_valid_reg || pix_out.ready;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign pix_in.ready = s1_en;
    assign fire         = pix_in.valid && s1_en;

    assign codes[0] = pix_in.red_in;
    assign codes[1] = pix_in.green_in;
    assign codes[2] = pix_in.blue_in;
    assign codes[3] = pix_in.alpha_in;

    rbd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .sof       (pix_in.start_of_image),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        rbd_lane u_lane
        (
            .clk       (clk),
            .hold_load (fire && ctl.hold_en),
            .s1_load   (fire && ctl.emit),
            .s2_load   (s2_en && s1_valid_reg),
            .pass_now  (ctl.pass),
            .pass_s1   (s1_pass_reg),
            .code      (codes[i]),
            .above     (above_reg[i*PAIR_W +: PAIR_W]),
            .pair_sum  (wr_data[i*PAIR_W +: PAIR_W]),
            .avg       (avgs[i])
        );
    end

    // read-before-write line store: even rows write, odd rows read
    always_ff @(posedge clk)
    begin
        if (fire && ctl.mem_wr)
            line_mem[ctl.addr] <= wr_data;
        if (fire && ctl.mem_rd)
            above_reg <= line_mem[ctl.addr];
    end

    always_comb
    begin
        s1_valid_next  = s1_en ? (fire && ctl.emit) : s1_valid_reg;
        out_valid_next = s2_en ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctl.emit)
            s1_pass_reg <= ctl.pass;
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_avg   = avgs[0];
    assign pix_out.green_avg = avgs[1];
    assign pix_out.blue_avg  = avgs[2];
    assign pix_out.alpha_avg = avgs[3];

`ifndef SYNTHESIS
    a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_en) |=> s1_valid_reg)
        else $error("middle stage word dropped during stall");
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (s1_valid_reg && pix_out.valid && !pix_out.ready))
        else $error("input stalled while pipeline has room");
    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(ctl.mem_wr && ctl.mem_rd))
        else $error("line store read and written by one pixel");
`endif

endmodule
`default_nettype wire

// ===== rtl/rbd_ctrl.sv =====
// Configuration registers, column and row counters, and per-pixel control decode.
`default_nettype none
module rbd_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire rbd_pkg::cfg_idx_t  cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic               fire,
    input  wire logic               sof,
    output rbd_pkg::rbd_ctl_t       ctl
);
    import rbd_pkg::*;

    logic [WIDTH_CFG_W-1:0] out_width_reg;
    logic                   halve_reg;
    logic [CNT_W-1:0]       col_reg, col_next;
    logic                   odd_reg, odd_next;
    logic                   phase_reg, phase_next;

    logic [CNT_W-1:0] eff_w;
    logic [CNT_W-1:0] col0;
    logic [CNT_W-1:0] col_use;
    logic [CNT_W-1:0] col_inc;
    logic             odd0;
    logic             phase0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg <= OUT_WIDTH_RESET;
            halve_reg     <= HALVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUT_WIDTH:    out_width_reg <= cfg_wdata[WIDTH_CFG_W-1:0];
                REG_HALVE_ENABLE: halve_reg     <= cfg_wdata[0];
            endcase
        end
    end

    always_comb
    begin
        if (out_width_reg == '0)
            eff_w = CNT_W'(1);
        else if (32'(out_width_reg) > 32'(MAX_OUT_WIDTH))
            eff_w = CNT_W'(MAX_OUT_WIDTH);
        else
            eff_w = CNT_W'(out_width_reg);
    end

    always_comb
    begin
        col0    = sof ? '0 : col_reg;
        odd0    = sof ? 1'b0 : odd_reg;
        phase0  = sof ? 1'b0 : phase_reg;
        col_use = (col0 >= eff_w) ? '0 : col0;
        col_inc = col_use + CNT_W'(1);

        col_next   = col_reg;
        odd_next   = odd_reg;
        phase_next = phase_reg;

        ctl.hold_en = 1'b0;
        ctl.pass    = 1'b0;
        ctl.emit    = 1'b0;
        ctl.mem_wr  = 1'b0;
        ctl.mem_rd  = 1'b0;
        ctl.addr    = col_use[ADDR_W-1:0];

        if (!halve_reg)
        begin
            ctl.pass   = 1'b1;
            ctl.emit   = 1'b1;
            col_next   = col0;
            odd_next   = odd0;
            phase_next = phase0;
        end
        else if (!phase0)
        begin
            ctl.hold_en = 1'b1;
            col_next    = col0;
            odd_next    = odd0;
            phase_next  = 1'b1;
        end
        else
        begin
            phase_next = 1'b0;
            ctl.mem_wr = !odd0;
            ctl.mem_rd = odd0;
            ctl.emit   = odd0;
            if (col_inc >= eff_w)
            begin
                col_next = '0;
                odd_next = !odd0;
            end
            else
            begin
                col_next = col_inc;
                odd_next = odd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            odd_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (fire)
        begin
            col_reg   <= col_next;
            odd_reg   <= odd_next;
            phase_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_addr_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (ctl.mem_wr || ctl.mem_rd)) |-> (CNT_W'(ctl.addr) < eff_w))
        else $error("line store address beyond row width");
    a_left_then_right: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctl.hold_en) |=> phase_reg)
        else $error("pair phase not set after left pixel");
    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(MAX_OUT_WIDTH))
        else $error("column count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/rbd_lane.sv =====
// One color channel: left-pixel hold, horizontal pair sum and vertical block sum.
`default_nettype none
module rbd_lane
(
    input  wire logic                        clk,
    input  wire logic                        hold_load,
    input  wire logic                        s1_load,
    input  wire logic                        s2_load,
    input  wire logic                        pass_now,
    input  wire logic                        pass_s1,
    input  wire logic [rbd_pkg::CODE_W-1:0]  code,
    input  wire logic [rbd_pkg::PAIR_W-1:0]  above,
    output      logic [rbd_pkg::PAIR_W-1:0]  pair_sum,
    output      logic [rbd_pkg::AVG_W-1:0]   avg
);
    import rbd_pkg::*;

    logic [CODE_W-1:0] left_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic [AVG_W-1:0]  avg_reg, avg_next;

    assign pair_sum = {1'b0, left_reg} + {1'b0, code};

    always_comb
    begin
        if (pass_s1)
            avg_next = {pair_reg[CODE_W-1:0], 2'b00};
        else
            avg_next = {1'b0, above} + {1'b0, pair_reg};
    end

    always_ff @(posedge clk)
    begin
        if (hold_load)
            left_reg <= code;
        if (s1_load)
            pair_reg <= pass_now ? {1'b0, code} : pair_sum;
        if (s2_load)
            avg_reg <= avg_next;
    end

    assign avg = avg_reg;

endmodule
`default_nettype wire
